// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/cdtc_pkg.sv =====
// ----------------------------------------------------------------------------
// cdtc_pkg
// operation codes, constants and month tables of the calendar converter
// ----------------------------------------------------------------------------
package cdtc_pkg;

	typedef enum logic [2:0] {
		OP_VALIDATE  = 3'd0,
		OP_JULIAN    = 3'd1,
		OP_TO_DOY    = 3'd2,
		OP_FROM_DOY  = 3'd3,
		OP_TO_MSOD   = 3'd4,
		OP_FROM_MSOD = 3'd5
	} op_t;

	localparam logic [26:0] MS_PER_HOUR = 27'd3600000;
	localparam logic [26:0] MS_PER_MIN  = 27'd60000;
	localparam logic [26:0] MS_MAX_DAY  = 27'd86401000;
	localparam logic [15:0] MS_MAX_SEC  = 16'd61000;
	localparam logic [4:0]  HOUR_MAX    = 5'd23;
	localparam logic [5:0]  MIN_MAX     = 6'd59;
	localparam logic [8:0]  DOY_MAX     = 9'd366;
	localparam logic [3:0]  MONTH_MAX   = 4'd12;

	// julian day terms
	localparam logic [14:0] JD_YEAR_OFS  = 15'd4800;
	localparam logic [14:0] JD_CENT_OFS  = 15'd4900;
	localparam logic [10:0] JD_YEAR_MUL  = 11'd1461;
	localparam logic [24:0] JD_OFFSET    = 25'd32075;

	// divide by 100 through a reciprocal, exact below 43690
	localparam logic [12:0] DIV100_MUL   = 13'd5243;
	localparam int          DIV100_SHIFT = 19;
	localparam logic [6:0]  HUNDRED      = 7'd100;

	// reciprocals for hour and minute split, exact over 27-bit inputs
	localparam int HOUR_SHIFT = 50;
	localparam int MIN_SHIFT  = 44;
	localparam longint unsigned HOUR_RECIP_L =
		((64'd1 << HOUR_SHIFT) + 64'd3599999) / 64'd3600000;
	localparam longint unsigned MIN_RECIP_L =
		((64'd1 << MIN_SHIFT) + 64'd59999) / 64'd60000;
	localparam logic [28:0] HOUR_RECIP = HOUR_RECIP_L[28:0];
	localparam logic [28:0] MIN_RECIP  = MIN_RECIP_L[28:0];

	// days before month idx+1 (idx 0 is january)
	function automatic logic [8:0] days_before(input logic leap, input logic [3:0] idx);
		logic [8:0] base;
		unique case (idx)
			4'd0:    base = 9'd0;
			4'd1:    base = 9'd31;
			4'd2:    base = 9'd59;
			4'd3:    base = 9'd90;
			4'd4:    base = 9'd120;
			4'd5:    base = 9'd151;
			4'd6:    base = 9'd181;
			4'd7:    base = 9'd212;
			4'd8:    base = 9'd243;
			4'd9:    base = 9'd273;
			4'd10:   base = 9'd304;
			4'd11:   base = 9'd334;
			default: base = 9'd0;
		endcase
		return base + 9'((leap && idx >= 4'd2 && idx <= 4'd11) ? 1 : 0);
	endfunction

	// days in month idx+1
	function automatic logic [4:0] days_in(input logic leap, input logic [3:0] idx);
		logic [4:0] n;
		unique case (idx)
			4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: n = 5'd31;
			4'd3, 4'd5, 4'd8, 4'd10:                    n = 5'd30;
			4'd1:    n = leap ? 5'd29 : 5'd28;
			default: n = 5'd0;
		endcase
		return n;
	endfunction

	// (367 * (m - 2 - 12 * l)) / 12 for every month code
	function automatic logic [8:0] month_term(input logic [3:0] m);
		logic [8:0] t;
		unique case (m)
			4'd0:  t = 9'd305;
			4'd1:  t = 9'd336;
			4'd2:  t = 9'd367;
			4'd3:  t = 9'd30;
			4'd4:  t = 9'd61;
			4'd5:  t = 9'd91;
			4'd6:  t = 9'd122;
			4'd7:  t = 9'd152;
			4'd8:  t = 9'd183;
			4'd9:  t = 9'd214;
			4'd10: t = 9'd244;
			4'd11: t = 9'd275;
			4'd12: t = 9'd305;
			4'd13: t = 9'd336;
			4'd14: t = 9'd367;
			4'd15: t = 9'd397;
			default: t = 9'd0;
		endcase
		return t;
	endfunction

endpackage

// ===== sv/calendar_date_time_converter.sv =====
// ----------------------------------------------------------------------------
// calendar_date_time_converter: gregorian date and time conversion pipeline
// path: an input beat passes stages s1, s2, s3 and s4 in order, the output register included
// throughput: one beat per cycle while m_axis_tready holds, set by the four register stages feeding each other
// reset: arst_n low clears all stage valid bits at once, payload registers keep no reset
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module calendar_date_time_converter (
	input  logic         clk,
	input  logic         arst_n,
	// input stream
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// year[13:0] month[17:14] day[22:18] hour[27:23] minute[33:28]
	// second_ms[49:34] day_of_year[58:50] seconds_of_day_ms[85:59] zero[87:86]
	input  logic [87:0]  s_axis_tdata,
	// operation[2:0]
	input  logic [2:0]   s_axis_tuser,
	// output stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// valid_res[0] julian_day[23:1] day_of_year_out[32:24] month_out[36:33]
	// day_out[45:37] hour_out[50:46] minute_out[56:51] second_ms_out[72:57]
	// seconds_of_day_out[99:73] zero[103:100]
	output logic [103:0] m_axis_tdata,
	// range_error[0]
	output logic [0:0]   m_axis_tuser
);

	// stage split:
	//   s1  reciprocal multiplies (year/100, ms/hour), julian year term prep, ms products
	//   s2  leap year, julian products, hour clamp and remainder, ms sum, range checks
	//   s3  julian sum, month tables, day of year search, ms/minute multiply
	//   s4  minute clamp and seconds remainder, field gating by operation (output reg)

	// ------------------------------------------------------------------
	// stage handshake: each stage takes a beat when empty or draining
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4 = !v_s4 || m_axis_tready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign s_axis_tready = rdy1;
	assign m_axis_tvalid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_axis_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// ------------------------------------------------------------------
	// input unpack
	// ------------------------------------------------------------------
	logic [2:0]  in_op;
	logic [13:0] in_year;
	logic [3:0]  in_month;
	logic [4:0]  in_day;
	logic [4:0]  in_hour;
	logic [5:0]  in_minute;
	logic [15:0] in_sms;
	logic [8:0]  in_doy;
	logic [26:0] in_sod;

	assign in_op     = s_axis_tuser;
	assign in_year   = s_axis_tdata[13:0];
	assign in_month  = s_axis_tdata[17:14];
	assign in_day    = s_axis_tdata[22:18];
	assign in_hour   = s_axis_tdata[27:23];
	assign in_minute = s_axis_tdata[33:28];
	assign in_sms    = s_axis_tdata[49:34];
	assign in_doy    = s_axis_tdata[58:50];
	assign in_sod    = s_axis_tdata[85:59];

	// ------------------------------------------------------------------
	// stage 1
	// ------------------------------------------------------------------
	logic        l_neg;          // fliegel term l is -1 for january, february and month 0
	logic [14:0] yl_c, y49_c;
	logic [26:0] qy_prod, q49_prod;
	logic [55:0] h_prod;

	assign l_neg    = (in_month <= 4'd2);
	assign yl_c     = 15'(in_year) + cdtc_pkg::JD_YEAR_OFS - 15'(l_neg);
	assign y49_c    = 15'(in_year) + cdtc_pkg::JD_CENT_OFS - 15'(l_neg);
	assign qy_prod  = 27'(in_year) * 27'(cdtc_pkg::DIV100_MUL);
	assign q49_prod = 27'(y49_c) * 27'(cdtc_pkg::DIV100_MUL);
	assign h_prod   = 56'(in_sod) * 56'(cdtc_pkg::HOUR_RECIP);

	logic [2:0]  op_s1;
	logic [13:0] year_s1;
	logic [3:0]  month_s1;
	logic [4:0]  day_s1;
	logic [4:0]  hour_s1;
	logic [5:0]  minute_s1;
	logic [15:0] sms_s1;
	logic [8:0]  doy_s1;
	logic [26:0] sod_s1;
	logic [14:0] yl_s1;
	logic [7:0]  qy_s1, q49_s1;
	logic [8:0]  mterm_s1;
	logic [5:0]  hest_s1;
	logic [26:0] msh_s1;
	logic [21:0] msm_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && s_axis_tvalid) begin
			op_s1     <= in_op;
			year_s1   <= in_year;
			month_s1  <= in_month;
			day_s1    <= in_day;
			hour_s1   <= in_hour;
			minute_s1 <= in_minute;
			sms_s1    <= in_sms;
			doy_s1    <= in_doy;
			sod_s1    <= in_sod;
			yl_s1     <= yl_c;
			qy_s1     <= qy_prod[cdtc_pkg::DIV100_SHIFT +: 8];
			q49_s1    <= q49_prod[cdtc_pkg::DIV100_SHIFT +: 8];
			mterm_s1  <= cdtc_pkg::month_term(in_month);
			hest_s1   <= h_prod[cdtc_pkg::HOUR_SHIFT +: 6];
			msh_s1    <= 27'(in_hour) * cdtc_pkg::MS_PER_HOUR;
			msm_s1    <= 22'(in_minute) * 22'(cdtc_pkg::MS_PER_MIN);
		end
	end

	// ------------------------------------------------------------------
	// stage 2
	// ------------------------------------------------------------------
	logic [13:0] r100_c;
	logic        leap_c;
	logic [25:0] a_prod;
	logic [9:0]  c_prod;
	logic [4:0]  h_clamp_c;

	assign r100_c    = year_s1 - 14'(qy_s1 * 14'(cdtc_pkg::HUNDRED));
	// divisible by 4, and not a century unless divisible by 400
	assign leap_c    = (year_s1[1:0] == 2'd0) && ((r100_c != 14'd0) || (qy_s1[1:0] == 2'd0));
	assign a_prod    = 26'(yl_s1) * 26'(cdtc_pkg::JD_YEAR_MUL);
	assign c_prod    = 10'(q49_s1) * 10'd3;
	assign h_clamp_c = (hest_s1 > 6'(cdtc_pkg::HOUR_MAX)) ? cdtc_pkg::HOUR_MAX : hest_s1[4:0];

	logic [2:0]  op_s2;
	logic [3:0]  month_s2;
	logic [4:0]  day_s2;
	logic [8:0]  doy_s2;
	logic        leap_s2;
	logic [23:0] a_s2;
	logic [7:0]  c_s2;
	logic [8:0]  mterm_s2;
	logic        time_ok_s2, ms_err_s2, sod_err_s2;
	logic [4:0]  hour_s2;
	logic [26:0] rem_s2;
	logic [26:0] msod_s2;

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			op_s2      <= op_s1;
			month_s2   <= month_s1;
			day_s2     <= day_s1;
			doy_s2     <= doy_s1;
			leap_s2    <= leap_c;
			a_s2       <= a_prod[25:2];
			c_s2       <= c_prod[9:2];
			mterm_s2   <= mterm_s1;
			time_ok_s2 <= (hour_s1 <= cdtc_pkg::HOUR_MAX) && (minute_s1 <= cdtc_pkg::MIN_MAX)
				&& (sms_s1 < cdtc_pkg::MS_MAX_SEC);
			ms_err_s2  <= (hour_s1 > cdtc_pkg::HOUR_MAX) || (minute_s1 > cdtc_pkg::MIN_MAX)
				|| (sms_s1 > cdtc_pkg::MS_MAX_SEC);
			sod_err_s2 <= (sod_s1 > cdtc_pkg::MS_MAX_DAY);
			hour_s2    <= h_clamp_c;
			rem_s2     <= sod_s1 - 27'(27'(h_clamp_c) * cdtc_pkg::MS_PER_HOUR);
			msod_s2    <= msh_s1 + 27'(msm_s1) + 27'(sms_s1);
		end
	end

	// ------------------------------------------------------------------
	// stage 3
	// ------------------------------------------------------------------
	logic [24:0] jd_sum;
	logic [3:0]  mon_idx;
	logic        mon_bad;
	logic [3:0]  doy_cnt;
	logic [3:0]  doy_month;
	logic [55:0] m_prod;

	assign jd_sum  = 25'(day_s2) + 25'(a_s2) + 25'(mterm_s2) - 25'(c_s2) - cdtc_pkg::JD_OFFSET;
	assign mon_idx = month_s2 - 4'd1;
	assign mon_bad = (month_s2 == 4'd0) || (month_s2 > cdtc_pkg::MONTH_MAX);
	assign m_prod  = 56'(rem_s2) * 56'(cdtc_pkg::MIN_RECIP);

	// month search: count month starts that lie below the day of year
	always_comb begin
		doy_cnt = 4'd0;
		for (int j = 1; j < 12; j++) begin
			if (doy_s2 > cdtc_pkg::days_before(leap_s2, 4'(j)))
				doy_cnt = doy_cnt + 4'd1;
		end
		doy_month = doy_cnt + 4'd1;
	end

	logic [2:0]  op_s3;
	logic [22:0] jd_s3;
	logic        valid_s3;
	logic        doy_err_s3;
	logic [8:0]  doy_out_s3;
	logic        fdoy_err_s3;
	logic [3:0]  month_out_s3;
	logic [8:0]  day_out_s3;
	logic        ms_err_s3, sod_err_s3;
	logic [26:0] msod_s3;
	logic [4:0]  hour_s3;
	logic [26:0] rem_s3;
	logic [11:0] mest_s3;

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			op_s3        <= op_s2;
			jd_s3        <= jd_sum[22:0];
			valid_s3     <= !mon_bad && (day_s2 != 5'd0)
				&& (day_s2 <= cdtc_pkg::days_in(leap_s2, mon_idx)) && time_ok_s2;
			doy_err_s3   <= mon_bad;
			doy_out_s3   <= cdtc_pkg::days_before(leap_s2, mon_idx) + 9'(day_s2);
			fdoy_err_s3  <= (doy_s2 > cdtc_pkg::DOY_MAX);
			month_out_s3 <= doy_month;
			day_out_s3   <= doy_s2 - cdtc_pkg::days_before(leap_s2, doy_cnt);
			ms_err_s3    <= ms_err_s2;
			sod_err_s3   <= sod_err_s2;
			msod_s3      <= msod_s2;
			hour_s3      <= hour_s2;
			rem_s3       <= rem_s2;
			mest_s3      <= m_prod[cdtc_pkg::MIN_SHIFT +: 12];
		end
	end

	// ------------------------------------------------------------------
	// stage 4: output register, fields not owned by the operation are zero
	// ------------------------------------------------------------------
	logic [5:0]  m_clamp_c;
	logic [26:0] sec_c;

	assign m_clamp_c = (mest_s3 > 12'(cdtc_pkg::MIN_MAX)) ? cdtc_pkg::MIN_MAX : mest_s3[5:0];
	assign sec_c     = rem_s3 - 27'(27'(m_clamp_c) * cdtc_pkg::MS_PER_MIN);

	logic        valid_res_c, range_error_c;
	logic [22:0] jd_c;
	logic [8:0]  doy_out_c;
	logic [3:0]  month_out_c;
	logic [8:0]  day_out_c;
	logic [4:0]  hour_out_c;
	logic [5:0]  minute_out_c;
	logic [15:0] sec_out_c;
	logic [26:0] msod_out_c;

	always_comb begin
		valid_res_c   = 1'b0;
		range_error_c = 1'b0;
		jd_c          = '0;
		doy_out_c     = '0;
		month_out_c   = '0;
		day_out_c     = '0;
		hour_out_c    = '0;
		minute_out_c  = '0;
		sec_out_c     = '0;
		msod_out_c    = '0;
		unique case (op_s3)
			cdtc_pkg::OP_VALIDATE: begin
				valid_res_c = valid_s3;
			end
			cdtc_pkg::OP_JULIAN: begin
				jd_c = jd_s3;
			end
			cdtc_pkg::OP_TO_DOY: begin
				range_error_c = doy_err_s3;
				if (!doy_err_s3) doy_out_c = doy_out_s3;
			end
			cdtc_pkg::OP_FROM_DOY: begin
				range_error_c = fdoy_err_s3;
				if (!fdoy_err_s3) begin
					month_out_c = month_out_s3;
					day_out_c   = day_out_s3;
				end
			end
			cdtc_pkg::OP_TO_MSOD: begin
				range_error_c = ms_err_s3;
				if (!ms_err_s3) msod_out_c = msod_s3;
			end
			cdtc_pkg::OP_FROM_MSOD: begin
				range_error_c = sod_err_s3;
				if (!sod_err_s3) begin
					hour_out_c   = hour_s3;
					minute_out_c = m_clamp_c;
					sec_out_c    = sec_c[15:0];
				end
			end
			default: begin
				// undefined operation codes leave every field zero
			end
		endcase
	end

	logic [2:0]  op_s4;
	logic        valid_res_s4, range_error_s4;
	logic [22:0] jd_s4;
	logic [8:0]  doy_out_s4;
	logic [3:0]  month_out_s4;
	logic [8:0]  day_out_s4;
	logic [4:0]  hour_out_s4;
	logic [5:0]  minute_out_s4;
	logic [15:0] sec_out_s4;
	logic [26:0] msod_out_s4;

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			op_s4          <= op_s3;
			valid_res_s4   <= valid_res_c;
			range_error_s4 <= range_error_c;
			jd_s4          <= jd_c;
			doy_out_s4     <= doy_out_c;
			month_out_s4   <= month_out_c;
			day_out_s4     <= day_out_c;
			hour_out_s4    <= hour_out_c;
			minute_out_s4  <= minute_out_c;
			sec_out_s4     <= sec_out_c;
			msod_out_s4    <= msod_out_c;
		end
	end

	assign m_axis_tdata = {4'd0, msod_out_s4, sec_out_s4, minute_out_s4, hour_out_s4,
		day_out_s4, month_out_s4, doy_out_s4, jd_s4, valid_res_s4};
	assign m_axis_tuser = range_error_s4;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	logic all_full, split_beat, split_ok, undef_beat, out_zero;

	assign all_full   = v_s1 && v_s2 && v_s3 && v_s4;
	assign split_beat = v_s4 && (op_s4 == cdtc_pkg::OP_FROM_MSOD) && !range_error_s4;
	assign split_ok   = (hour_out_s4 <= cdtc_pkg::HOUR_MAX) && (minute_out_s4 <= cdtc_pkg::MIN_MAX)
		&& (sec_out_s4 <= cdtc_pkg::MS_MAX_SEC);
	assign undef_beat = arst_n && v_s4 && (op_s4 > 3'(cdtc_pkg::OP_FROM_MSOD));
	assign out_zero   = (m_axis_tdata == '0) && !m_axis_tuser[0];

	// input stalls only when every stage holds a beat
	`ASSERT_RST(a_stall_full, !s_axis_tready |-> all_full, "stall with a free stage")
	// validate never reports a range error, and only validate sets valid_res
	`ASSERT_RST(a_flag_excl, m_axis_tvalid |-> !(m_axis_tuser[0] & m_axis_tdata[0]), "flags both set")
	// split of ms of day stays within the clamped limits
	`ASSERT_RST(a_split_rng, split_beat |-> split_ok, "ms of day split out of range")
	// undefined operations give an all-zero beat
	`ASSERT_ALWAYS(a_undef_zero, undef_beat |-> out_zero, "undefined operation gave data")

endmodule

// ===== sim/tb_calendar_date_time_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_calendar_date_time_converter
// self-checking bench for the gregorian date and time converter: every beat
// accepted on the input stream is run through a behavioral calendar model and
// the converted fields are checked against the output stream in order, while
// both streams idle and stall at random
// ----------------------------------------------------------------------------
module tb_calendar_date_time_converter;

	// codes the package leaves unnamed, expected to give an all-zero result
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	// calendar limits
	localparam int unsigned MS_HOUR         = 3600000;
	localparam int unsigned MS_MINUTE       = 60000;
	localparam int unsigned MS_DAY_LIMIT    = 86401000;
	localparam int unsigned MS_SECOND_LIMIT = 61000;
	localparam int unsigned LAST_HOUR       = 23;
	localparam int unsigned LAST_MINUTE     = 59;
	localparam int unsigned LAST_MONTH      = 12;
	localparam int unsigned LAST_DOY        = 366;

	localparam int OUTPUT_HOLD_CYCLES = 300;
	localparam int RANDOM_ITEMS       = 1400;
	localparam int HOLD_ITEMS         = 100;

	typedef struct {
		logic [2:0]  op;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [15:0] second_ms;
		logic [8:0]  day_of_year;
		logic [26:0] seconds_of_day_ms;
	} cal_request_t;

	typedef struct {
		logic        valid_res;
		logic        range_error;
		logic [22:0] julian_day;
		logic [8:0]  day_of_year_out;
		logic [3:0]  month_out;
		logic [8:0]  day_out;
		logic [4:0]  hour_out;
		logic [5:0]  minute_out;
		logic [15:0] second_ms_out;
		logic [26:0] seconds_of_day_out;
	} cal_result_t;

	// days before each month and month lengths, common year then leap year
	int unsigned cum_days [2][12] = '{
		'{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334},
		'{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335}
	};
	int unsigned month_len [2][12] = '{
		'{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31},
		'{31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31}
	};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [87:0]  s_axis_tdata = '0;
	logic [2:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [103:0] m_axis_tdata;
	logic [0:0]   m_axis_tuser;

	cal_result_t pending_results [$];
	int          mismatch_count = 0;
	int          results_checked = 0;
	int          op_count [8] = '{default: 0};

	// sender burst state
	bit sender_gaps_on = 1'b1;
	int burst_left = 0;

	// long output hold requests: bumped by the test, served by the receiver
	int hold_requests = 0;
	int hold_served = 0;
	int longest_hold = 0;

	calendar_date_time_converter u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// calendar model
	// ------------------------------------------------------------------

	function automatic bit leap_year(input int unsigned y);
		return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
	endfunction

	// fliegel-van flandern day number, truncating division as in integer math
	function automatic logic [22:0] julian_day_number(input cal_request_t q);
		longint y;
		longint m;
		longint d;
		longint l;
		longint r;
		y = q.year;
		m = q.month;
		d = q.day;
		l = (m - 14) / 12;
		r = d - 32075 + (1461 * (y + 4800 + l)) / 4 + (367 * (m - 2 - l * 12)) / 12
			- (3 * ((y + 4900 + l) / 100)) / 4;
		if (r < 0)
			r = 0;
		return r[22:0];
	endfunction

	function automatic cal_result_t convert_calendar(input cal_request_t q);
		cal_result_t res;
		bit          lp;
		int unsigned mon;
		int unsigned h;
		int unsigned m;
		int unsigned rem;
		res = '{default: '0};
		lp = leap_year(q.year);
		mon = q.month;
		case (q.op)
			cdtc_pkg::OP_VALIDATE: begin
				if (mon >= 1 && mon <= LAST_MONTH) begin
					if (q.day >= 1 && q.day <= month_len[lp][mon - 1] && q.hour <= LAST_HOUR
						&& q.minute <= LAST_MINUTE && q.second_ms < MS_SECOND_LIMIT)
						res.valid_res = 1'b1;
				end
			end
			cdtc_pkg::OP_JULIAN: res.julian_day = julian_day_number(q);
			cdtc_pkg::OP_TO_DOY: begin
				if (mon < 1 || mon > LAST_MONTH)
					res.range_error = 1'b1;
				else
					res.day_of_year_out = 9'(cum_days[lp][mon - 1] + q.day);
			end
			cdtc_pkg::OP_FROM_DOY: begin
				if (q.day_of_year > LAST_DOY) begin
					res.range_error = 1'b1;
				end else begin
					m = 1;
					while (m < 12 && q.day_of_year > cum_days[lp][m])
						m++;
					res.month_out = 4'(m);
					res.day_out = 9'(q.day_of_year - cum_days[lp][m - 1]);
				end
			end
			cdtc_pkg::OP_TO_MSOD: begin
				if (q.hour > LAST_HOUR || q.minute > LAST_MINUTE || q.second_ms > MS_SECOND_LIMIT)
					res.range_error = 1'b1;
				else
					res.seconds_of_day_out = 27'(q.hour * MS_HOUR + q.minute * MS_MINUTE
						+ q.second_ms);
			end
			cdtc_pkg::OP_FROM_MSOD: begin
				if (q.seconds_of_day_ms > MS_DAY_LIMIT) begin
					res.range_error = 1'b1;
				end else begin
					// past the last full hour and minute the rest stays in seconds
					h = q.seconds_of_day_ms / MS_HOUR;
					if (h > LAST_HOUR)
						h = LAST_HOUR;
					rem = q.seconds_of_day_ms - h * MS_HOUR;
					m = rem / MS_MINUTE;
					if (m > LAST_MINUTE)
						m = LAST_MINUTE;
					res.hour_out = 5'(h);
					res.minute_out = 6'(m);
					res.second_ms_out = 16'(rem - m * MS_MINUTE);
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// ------------------------------------------------------------------
	// input side
	// ------------------------------------------------------------------

	function automatic cal_request_t make_request(input logic [2:0] op, input int unsigned year,
		input int unsigned month, input int unsigned day, input int unsigned hour,
		input int unsigned minute, input int unsigned second_ms, input int unsigned doy,
		input int unsigned sod);
		cal_request_t q;
		q.op = op;
		q.year = 14'(year);
		q.month = 4'(month);
		q.day = 5'(day);
		q.hour = 5'(hour);
		q.minute = 6'(minute);
		q.second_ms = 16'(second_ms);
		q.day_of_year = 9'(doy);
		q.seconds_of_day_ms = 27'(sod);
		return q;
	endfunction

	// mostly well-formed dates and times, the rest anything the fields hold
	function automatic cal_request_t random_request(input logic [2:0] op);
		cal_request_t q;
		bit           lp;
		q = make_request(op, $urandom_range(0, 9999), $urandom_range(0, 15), $urandom_range(0, 31),
			$urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 65535),
			$urandom_range(0, 511), $urandom_range(0, 27'h7FFFFFF));
		if ($urandom_range(0, 7) == 0)
			q.year = 14'($urandom_range(0, 99) * 100);
		if ($urandom_range(0, 4) != 0) begin
			lp = leap_year(q.year);
			q.month = 4'($urandom_range(1, 12));
			q.day = 5'($urandom_range(1, month_len[lp][q.month - 1]));
			if ($urandom_range(0, 5) == 0)
				q.day = 5'(month_len[lp][q.month - 1]);
			q.hour = 5'($urandom_range(0, LAST_HOUR));
			q.minute = 6'($urandom_range(0, LAST_MINUTE));
			q.second_ms = 16'($urandom_range(0, MS_SECOND_LIMIT));
			q.day_of_year = 9'($urandom_range(0, LAST_DOY));
			q.seconds_of_day_ms = 27'($urandom_range(0, MS_DAY_LIMIT));
			// the last second of a leap-second day, where hour and minute clamp
			if ($urandom_range(0, 7) == 0)
				q.seconds_of_day_ms = 27'(MS_DAY_LIMIT - $urandom_range(0, 1000));
		end
		return q;
	endfunction

	// offers one beat, idling between bursts, and returns once it is taken
	task automatic send_request(input cal_request_t q);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = sender_gaps_on ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= q.op;
		s_axis_tdata <= {2'b00, q.seconds_of_day_ms, q.day_of_year, q.second_ms, q.minute,
			q.hour, q.day, q.month, q.year};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_results.push_back(convert_calendar(q));
		op_count[q.op]++;
	endtask

	// ------------------------------------------------------------------
	// output side: checks each beat, then picks the next ready value
	// ------------------------------------------------------------------

	task automatic check_field(input string name, input int unsigned exp_val,
		input int unsigned act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			mismatch_count++;
		end
	endtask

	task automatic check_result_beat();
		cal_result_t exp_res;
		if (pending_results.size() == 0) begin
			$error("output beat with no result outstanding");
			mismatch_count++;
			return;
		end
		exp_res = pending_results.pop_front();
		results_checked++;
		check_field("valid_res", exp_res.valid_res, m_axis_tdata[0]);
		check_field("range_error", exp_res.range_error, m_axis_tuser[0]);
		check_field("julian_day", exp_res.julian_day, m_axis_tdata[23:1]);
		check_field("day_of_year_out", exp_res.day_of_year_out, m_axis_tdata[32:24]);
		check_field("month_out", exp_res.month_out, m_axis_tdata[36:33]);
		check_field("day_out", exp_res.day_out, m_axis_tdata[45:37]);
		check_field("hour_out", exp_res.hour_out, m_axis_tdata[50:46]);
		check_field("minute_out", exp_res.minute_out, m_axis_tdata[56:51]);
		check_field("second_ms_out", exp_res.second_ms_out, m_axis_tdata[72:57]);
		check_field("seconds_of_day_out", exp_res.seconds_of_day_out, m_axis_tdata[99:73]);
		check_field("tdata pad", 0, m_axis_tdata[103:100]);
	endtask

	int recv_cycle = 0;
	int recv_mode = 0;
	int hold_left = 0;

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_result_beat();
		// draw a new random stall pattern from the four receiver modes
		if (recv_cycle % 48 == 0)
			recv_mode = $urandom_range(0, 3);
		recv_cycle++;
		if (hold_left == 0 && hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = OUTPUT_HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			if (OUTPUT_HOLD_CYCLES - hold_left > longest_hold)
				longest_hold = OUTPUT_HOLD_CYCLES - hold_left;
			m_axis_tready <= 1'b0;
		end else begin
			case (recv_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 3) != 0);
				2: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= (recv_cycle % 5 != 0);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// leap rule on all three kinds of year, month and day edges, time limits
	task automatic test_validate();
		send_request(make_request(cdtc_pkg::OP_VALIDATE, 2024, 2, 29, 23, 59, 60999, 0, 0));
		send_request(make_request(cdtc_pkg::OP_VALIDATE, 1900, 2, 29, 0, 0, 0, 0, 0));
		send_request(make_request(cdtc_pkg::OP_VALIDATE, 2000, 2, 29, 12, 30, 0, 0, 0));
		send_request(make_request(cdtc_pkg::OP_VALIDATE, 2023, 0, 10, 0, 0, 0, 0, 0));
		send_request(make_request(cdtc_pkg::OP_VALIDATE, 2023, 13, 10, 0, 0, 0, 0, 0));
		send_request(make_request(cdtc_pkg::OP_VALIDATE, 2023, 4, 0, 0, 0, 0, 0, 0));
		send_request(make_request(cdtc_pkg::OP_VALIDATE, 2023, 4, 31, 0, 0, 0, 0, 0));
		send_request(make_request(cdtc_pkg::OP_VALIDATE, 2023, 5, 5, 24, 60, 61000, 0, 0));
	endtask

	// known epoch day plus all-zero fields and the largest month and day codes
	task automatic test_julian_day();
		send_request(make_request(cdtc_pkg::OP_JULIAN, 2000, 1, 1, 0, 0, 0, 0, 0));
		send_request(make_request(cdtc_pkg::OP_JULIAN, 0, 0, 0, 0, 0, 0, 0, 0));
		send_request(make_request(cdtc_pkg::OP_JULIAN, 9999, 14, 31, 0, 0, 0, 0, 0));
		send_request(make_request(cdtc_pkg::OP_JULIAN, 9999, 15, 31, 31, 63, 65535, 511,
			27'h7FFFFFF));
	endtask

	// last day of a leap year, bad months, day zero before the first of january
	task automatic test_to_day_of_year();
		send_request(make_request(cdtc_pkg::OP_TO_DOY, 2024, 12, 31, 0, 0, 0, 0, 0));
		send_request(make_request(cdtc_pkg::OP_TO_DOY, 2024, 0, 5, 0, 0, 0, 0, 0));
		send_request(make_request(cdtc_pkg::OP_TO_DOY, 2024, 15, 5, 0, 0, 0, 0, 0));
		send_request(make_request(cdtc_pkg::OP_TO_DOY, 2023, 1, 0, 0, 0, 0, 0, 0));
	endtask

	// day zero, day 366 of a common year spilling into december 32, overflow
	task automatic test_from_day_of_year();
		send_request(make_request(cdtc_pkg::OP_FROM_DOY, 2023, 0, 0, 0, 0, 0, 0, 0));
		send_request(make_request(cdtc_pkg::OP_FROM_DOY, 2023, 0, 0, 0, 0, 0, 366, 0));
		send_request(make_request(cdtc_pkg::OP_FROM_DOY, 2024, 0, 0, 0, 0, 0, 60, 0));
		send_request(make_request(cdtc_pkg::OP_FROM_DOY, 2024, 0, 0, 0, 0, 0, 367, 0));
	endtask

	// largest legal time of day and each field just past its limit
	task automatic test_to_ms_of_day();
		send_request(make_request(cdtc_pkg::OP_TO_MSOD, 0, 0, 0, 23, 59, 61000, 0, 0));
		send_request(make_request(cdtc_pkg::OP_TO_MSOD, 0, 0, 0, 24, 0, 0, 0, 0));
		send_request(make_request(cdtc_pkg::OP_TO_MSOD, 0, 0, 0, 0, 60, 0, 0, 0));
		send_request(make_request(cdtc_pkg::OP_TO_MSOD, 0, 0, 0, 0, 0, 61001, 0, 0));
	endtask

	// clamped leap second at the end of day, first value past it, all ones
	task automatic test_split_ms_of_day();
		send_request(make_request(cdtc_pkg::OP_FROM_MSOD, 0, 0, 0, 0, 0, 0, 0, MS_DAY_LIMIT));
		send_request(make_request(cdtc_pkg::OP_FROM_MSOD, 0, 0, 0, 0, 0, 0, 0,
			MS_DAY_LIMIT + 1));
		send_request(make_request(cdtc_pkg::OP_FROM_MSOD, 0, 0, 0, 0, 0, 0, 0, 27'h7FFFFFF));
	endtask

	task automatic test_undefined_ops();
		send_request(make_request(OP_SPARE_6, 2024, 2, 29, 23, 59, 0, 100, 1000));
		send_request(make_request(OP_SPARE_7, 9999, 15, 31, 31, 63, 65535, 511, 27'h7FFFFFF));
	endtask

	// random mix in segments, some with idle gaps, some back to back
	task automatic test_random_mix();
		logic [2:0] op;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 200 == 0)
				sender_gaps_on = $urandom_range(0, 2) != 0;
			op = ($urandom_range(0, 31) < 30) ? 3'($urandom_range(0, 5))
				: 3'($urandom_range(OP_SPARE_6, OP_SPARE_7));
			send_request(random_request(op));
		end
		sender_gaps_on = 1'b1;
	endtask

	// receiver holds off long enough that the pipeline fills and input stalls
	task automatic test_output_hold();
		sender_gaps_on = 1'b0;
		hold_requests <= hold_requests + 1;
		for (int i = 0; i < HOLD_ITEMS; i++)
			send_request(random_request(3'($urandom_range(0, 5))));
		sender_gaps_on = 1'b1;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_validate();
		test_julian_day();
		test_to_day_of_year();
		test_from_day_of_year();
		test_to_ms_of_day();
		test_split_ms_of_day();
		test_undefined_ops();
		test_random_mix();
		test_output_hold();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// any stray beat still in the pipeline shows up well within this wait
		repeat (12) @(posedge clk);
		$display("covered %0d beats by operation 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
			op_count.sum(), op_count[0], op_count[1], op_count[2], op_count[3], op_count[4],
			op_count[5], op_count[6], op_count[7]);
		$display("checked %0d results, longest output hold %0d cycles, %0d field errors",
			results_checked, longest_hold, mismatch_count);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog, far above the slowest legal run
	initial begin
		#5000000;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("Mismatches found");
		$finish;
	end

endmodule
